// File: rtl/point_cluster_gate_centroid_assert.svh
// Assertion macros, clocked on clk_i and disabled while rst_ni is low.
`ifndef POINT_CLUSTER_GATE_CENTROID_ASSERT_SVH
`define POINT_CLUSTER_GATE_CENTROID_ASSERT_SVH
`ifndef SYNTH
`define PCGC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define PCGC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition");
`else
`define PCGC_ASSERT(lbl, prop)
`define PCGC_NEVER(lbl, expr)
`endif
`endif

// File: rtl/pcgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcgc_pkg;
  localparam int unsigned MaxPointsDef = 256;
  localparam int unsigned CoordBitsDef = 10;
  localparam int unsigned RegW         = 11;
  localparam logic [RegW-1:0] GateReset = 11'd50;
  localparam logic [RegW-1:0] CullReset = 11'd40;
  localparam int unsigned CornerStart  = 1000;

  typedef enum logic {
    REG_GATE = 1'b0,
    REG_CULL = 1'b1
  } reg_idx_e;
endpackage
`default_nettype wire

// File: rtl/pcgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module pcgc_div #(
  parameter int unsigned SUM_W = 19,
  parameter int unsigned DEN_W = 9,
  parameter int unsigned Q_W   = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] num_x_i,
  input  wire logic [SUM_W-1:0] num_y_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [Q_W-1:0]        quo_x_o,
  output logic [Q_W-1:0]        quo_y_o
);
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  num_q [2];
  logic [SUM_W-1:0]  num_d [2];
  logic [DEN_W-1:0]  rem_q [2];
  logic [DEN_W-1:0]  rem_d [2];
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] steps_q;
  logic              busy_q;
  logic              done_q;

  always_comb begin
    logic [DEN_W:0] shifted;
    for (int l = 0; l < 2; l++) begin
      shifted = {rem_q[l], num_q[l][SUM_W-1]};
      if (shifted >= {1'b0, den_q}) begin
        rem_d[l] = DEN_W'(shifted - {1'b0, den_q});
        num_d[l] = {num_q[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[l] = shifted[DEN_W-1:0];
        num_d[l] = {num_q[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        steps_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        steps_q <= steps_q - 1'b1;
        if (steps_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q[0] <= num_x_i;
      num_q[1] <= num_y_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      den_q    <= den_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o  = done_q;
  assign quo_x_o = num_q[0][Q_W-1:0];
  assign quo_y_o = num_q[1][Q_W-1:0];
endmodule
`default_nettype wire

// File: rtl/point_cluster_gate_centroid.sv
// Channel   | Handshake              | Payload
// request   | start_i, busy_o        | func_i, point_x_i, point_y_i
// result    | valid_o (one cycle)    | accepted_o, centre_*_o, point_count_o, half_*_o,
//           |                        | corner_*_o
// config    | cfg_we_i, cfg_idx_i    | cfg_data_i
// Add: a gate step, then centroid division when the point is stored,
//   then an extent walk through the point memory.
// Cull: a compaction walk, the division when any point is kept, then the extent walk.
// The single read port of the point memory sets the walk lengths.
// After reset the store is empty; no clearing pass. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cluster_gate_centroid_assert.svh"
module point_cluster_gate_centroid #(
  parameter int unsigned MAX_POINTS = pcgc_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = pcgc_pkg::CoordBitsDef,
  localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    func_i,
  input  wire logic [COORD_BITS-1:0]   point_x_i,
  input  wire logic [COORD_BITS-1:0]   point_y_i,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [pcgc_pkg::RegW-1:0] cfg_data_i,
  output logic                         valid_o,
  output logic                         accepted_o,
  output logic [COORD_BITS-1:0]        centre_x_o,
  output logic [COORD_BITS-1:0]        centre_y_o,
  output logic [CNT_W-1:0]             point_count_o,
  output logic [COORD_BITS-1:0]        half_width_o,
  output logic [COORD_BITS-1:0]        half_height_o,
  output logic [COORD_BITS-1:0]        corner_x_o,
  output logic [COORD_BITS-1:0]        corner_y_o
);
  localparam int unsigned AW       = $clog2(MAX_POINTS);
  localparam int unsigned SUM_W    = COORD_BITS + CNT_W;
  localparam int unsigned D2_W     = 2 * COORD_BITS + 1;
  localparam int unsigned R2_W     = 2 * (pcgc_pkg::RegW + 1);
  localparam int unsigned CMP_W    = (D2_W > R2_W) ? D2_W : R2_W;
  localparam int unsigned CORNER_W = (COORD_BITS > 10) ? COORD_BITS : 10;
  localparam int unsigned MW       = 2 * COORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_CULL = 5'b00100,
    S_DIV  = 5'b01000,
    S_EXT  = 5'b10000
  } state_e;

  state_e state_q;
  logic [pcgc_pkg::RegW-1:0] gate_q, cull_q;
  logic [COORD_BITS-1:0] pt_x_q, pt_y_q, cen_x_q, cen_y_q, hw_q, hh_q;
  logic [CORNER_W-1:0]   cx_q, cy_q;
  logic [CNT_W-1:0]      count_q, kept_q, idx_q;
  logic [SUM_W-1:0]      sum_x_q, sum_y_q;
  logic                  acc_q, pend_q, div_go_q, valid_q;

  logic [MW-1:0]         mem [MAX_POINTS];
  logic [MW-1:0]         rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [MW-1:0]         mem_wd;

  logic [COORD_BITS-1:0] rx, ry, ax, ay, dx, dy, ex, ey;
  logic [CMP_W-1:0]      d2, thr;
  logic [pcgc_pkg::RegW:0] cull_p1;
  logic                  near, accept_req, walk_end, issue;
  logic                  div_done;
  logic [COORD_BITS-1:0] quo_x, quo_y;

  assign rx = rdata_q[MW-1:COORD_BITS];
  assign ry = rdata_q[COORD_BITS-1:0];
  assign accept_req = start_i && (state_q == S_IDLE);
  assign issue    = (idx_q != count_q);
  assign walk_end = !issue && !pend_q;

  // shared squared-distance unit: new point during add, stored point during cull
  always_comb begin
    ax = (state_q == S_ADD) ? pt_x_q : rx;
    ay = (state_q == S_ADD) ? pt_y_q : ry;
    dx = (ax > cen_x_q) ? ax - cen_x_q : cen_x_q - ax;
    dy = (ay > cen_y_q) ? ay - cen_y_q : cen_y_q - ay;
    d2 = CMP_W'(dx * dx) + CMP_W'(dy * dy);
    cull_p1 = {1'b0, cull_q} + 1'b1;
    thr = (state_q == S_ADD) ? CMP_W'(gate_q * gate_q) : CMP_W'(cull_p1 * cull_p1);
    near = d2 < thr;
    ex = (rx > cen_x_q) ? rx - cen_x_q : cen_x_q - rx;
    ey = (ry > cen_y_q) ? ry - cen_y_q : cen_y_q - ry;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = count_q[AW-1:0];
    mem_wd = {pt_x_q, pt_y_q};
    if (state_q == S_ADD) begin
      mem_we = (count_q != CNT_W'(MAX_POINTS)) && (count_q == '0 || near);
    end else if (state_q == S_CULL) begin
      mem_we = pend_q && near;
      mem_wa = kept_q[AW-1:0];
      mem_wd = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[idx_q[AW-1:0]];
  end

  pcgc_div #(
    .SUM_W (SUM_W),
    .DEN_W (CNT_W),
    .Q_W   (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_x_i (sum_x_q),
    .num_y_i (sum_y_q),
    .den_i   (count_q),
    .done_o  (div_done),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      gate_q   <= pcgc_pkg::GateReset;
      cull_q   <= pcgc_pkg::CullReset;
      count_q  <= '0;
      kept_q   <= '0;
      idx_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      cen_x_q  <= '0;
      cen_y_q  <= '0;
      pt_x_q   <= '0;
      pt_y_q   <= '0;
      acc_q    <= 1'b0;
      pend_q   <= 1'b0;
      div_go_q <= 1'b0;
      valid_q  <= 1'b0;
      hw_q     <= '0;
      hh_q     <= '0;
      cx_q     <= CORNER_W'(pcgc_pkg::CornerStart);
      cy_q     <= CORNER_W'(pcgc_pkg::CornerStart);
      accepted_o    <= 1'b0;
      centre_x_o    <= '0;
      centre_y_o    <= '0;
      point_count_o <= '0;
      half_width_o  <= '0;
      half_height_o <= '0;
      corner_x_o    <= '0;
      corner_y_o    <= '0;
    end else begin
      valid_q  <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (pcgc_pkg::reg_idx_e'(cfg_idx_i))
          pcgc_pkg::REG_GATE: gate_q <= cfg_data_i;
          pcgc_pkg::REG_CULL: cull_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept_req) begin
            pt_x_q <= point_x_i;
            pt_y_q <= point_y_i;
            idx_q  <= '0;
            pend_q <= 1'b0;
            if (func_i) begin
              acc_q   <= 1'b1;
              kept_q  <= '0;
              sum_x_q <= '0;
              sum_y_q <= '0;
              state_q <= S_CULL;
            end else begin
              state_q <= S_ADD;
            end
          end
        end
        S_ADD: begin
          hw_q <= '0;
          hh_q <= '0;
          cx_q <= CORNER_W'(pcgc_pkg::CornerStart);
          cy_q <= CORNER_W'(pcgc_pkg::CornerStart);
          acc_q <= mem_we;
          if (mem_we) begin
            count_q  <= count_q + 1'b1;
            sum_x_q  <= sum_x_q + SUM_W'(pt_x_q);
            sum_y_q  <= sum_y_q + SUM_W'(pt_y_q);
            div_go_q <= 1'b1;
            state_q  <= S_DIV;
          end else begin
            state_q <= S_EXT;
          end
        end
        S_CULL: begin
          // reads run ahead of compaction writes, so kept never passes idx
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          pend_q <= issue;
          if (pend_q && near) begin
            kept_q  <= kept_q + 1'b1;
            sum_x_q <= sum_x_q + SUM_W'(rx);
            sum_y_q <= sum_y_q + SUM_W'(ry);
          end
          if (walk_end) begin
            count_q <= kept_q;
            idx_q   <= '0;
            hw_q    <= '0;
            hh_q    <= '0;
            cx_q    <= CORNER_W'(pcgc_pkg::CornerStart);
            cy_q    <= CORNER_W'(pcgc_pkg::CornerStart);
            if (kept_q != '0) begin
              div_go_q <= 1'b1;
              state_q  <= S_DIV;
            end else begin
              state_q <= S_EXT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cen_x_q <= quo_x;
            cen_y_q <= quo_y;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_EXT;
          end
        end
        S_EXT: begin
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          pend_q <= issue;
          if (pend_q) begin
            if (ex > hw_q) hw_q <= ex;
            if (ey > hh_q) hh_q <= ey;
            if (CORNER_W'(rx) < cx_q) cx_q <= CORNER_W'(rx);
            if (CORNER_W'(ry) < cy_q) cy_q <= CORNER_W'(ry);
          end
          if (walk_end) begin
            valid_q       <= 1'b1;
            accepted_o    <= acc_q;
            centre_x_o    <= cen_x_q;
            centre_y_o    <= cen_y_q;
            point_count_o <= count_q;
            half_width_o  <= (hw_q == '0) ? COORD_BITS'(1) : hw_q;
            half_height_o <= (hh_q == '0) ? COORD_BITS'(1) : hh_q;
            corner_x_o    <= cx_q[COORD_BITS-1:0];
            corner_y_o    <= cy_q[COORD_BITS-1:0];
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;

  `PCGC_NEVER(a_count_bound, count_q > CNT_W'(MAX_POINTS))
  `PCGC_ASSERT(a_result_idle, valid_o |-> !busy_o)
  `PCGC_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `PCGC_NEVER(a_kept_bound, (state_q == S_CULL) && (kept_q > idx_q))
endmodule
`default_nettype wire
